[rtl/delta_timeout_queue_unit_defines.svh]
// Assertion macros for the checker file of the timeout queue.
`ifndef DELTA_TIMEOUT_QUEUE_UNIT_DEFINES_SVH
`define DELTA_TIMEOUT_QUEUE_UNIT_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define DTQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define DTQ_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[rtl/dtq_pkg.sv]
`default_nettype none

package dtq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int DELAY_W = 32;
  localparam int ST_W    = 2;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_NONE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_FIX,
    S_INS,
    S_RIPPLE,
    S_DEQ,
    S_DSHIFT,
    S_TICK,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    logic            out_valid;
    logic [ID_W-1:0] out_id;
    logic [ST_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_msg_t;

endpackage

`default_nettype wire

[rtl/dtq_if.sv]
`default_nettype none

interface dtq_req_if;
  import dtq_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [ID_W-1:0]    msg_id;
  logic [DELAY_W-1:0] delay;

  modport source (output valid, opcode, msg_id, delay, input ready);
  modport sink (input valid, opcode, msg_id, delay, output ready);
endinterface

interface dtq_rsp_if;
  import dtq_pkg::*;

  logic            valid;
  logic            ready;
  logic            out_valid;
  logic [ID_W-1:0] out_id;
  logic [ST_W-1:0] status;

  modport source (output valid, out_valid, out_id, status, input ready);
  modport sink (input valid, out_valid, out_id, status, output ready);
endinterface

`default_nettype wire

[rtl/dtq_alu.sv]
`default_nettype none

module dtq_alu #(
  parameter int WIDTH = dtq_pkg::TIME_WIDTH_DEF
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             lt
);

  logic [WIDTH:0] wide;

  // The borrow out of the subtraction tells whether a is below b.
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[WIDTH-1:0];
  assign lt   = wide[WIDTH];

endmodule

`default_nettype wire

[rtl/dtq_mem.sv]
`default_nettype none

module dtq_mem #(
  parameter int DEPTH = dtq_pkg::DEPTH_DEF,
  parameter int WIDTH = dtq_pkg::ID_W + dtq_pkg::TIME_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/dtq_seq.sv]
`default_nettype none

module dtq_seq #(
  parameter int DEPTH      = dtq_pkg::DEPTH_DEF,
  parameter int TIME_WIDTH = dtq_pkg::TIME_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  dtq_req_if.sink                                req,
  output logic                                   mem_we,
  output logic [$clog2(DEPTH)-1:0]               mem_waddr,
  output logic [dtq_pkg::ID_W+TIME_WIDTH-1:0]    mem_wdata,
  output logic [$clog2(DEPTH)-1:0]               mem_raddr,
  input  logic [dtq_pkg::ID_W+TIME_WIDTH-1:0]    mem_rdata,
  output logic [TIME_WIDTH-1:0]                  alu_a,
  output logic [TIME_WIDTH-1:0]                  alu_b,
  input  logic [TIME_WIDTH-1:0]                  alu_diff,
  input  logic                                   alu_lt,
  output dtq_pkg::result_msg_t                   res,
  input  logic                                   res_taken
);
  import dtq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_W + TIME_WIDTH;

  seq_state_t            state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         pos, pos_next;
  logic [AW-1:0]         idx, idx_next;
  logic [TIME_WIDTH-1:0] rem, rem_next;
  logic [ID_W-1:0]       new_id, new_id_next;
  logic [ID_W-1:0]       carry_id, carry_id_next;
  logic [TIME_WIDTH-1:0] carry_delta, carry_delta_next;
  logic                  first, first_next;
  result_t               result, result_next;

  logic [ID_W-1:0]       rd_id;
  logic [TIME_WIDTH-1:0] rd_delta;
  logic [TIME_WIDTH-1:0] delay_sat;

  assign rd_id    = mem_rdata[EW-1:TIME_WIDTH];
  assign rd_delta = mem_rdata[TIME_WIDTH-1:0];

  if (TIME_WIDTH >= DELAY_W) begin : g_wide
    assign delay_sat = TIME_WIDTH'(req.delay);
  end else begin : g_narrow
    assign delay_sat = (|req.delay[DELAY_W-1:TIME_WIDTH]) ? '1 : req.delay[TIME_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    idx         <= idx_next;
    rem         <= rem_next;
    new_id      <= new_id_next;
    carry_id    <= carry_id_next;
    carry_delta <= carry_delta_next;
    first       <= first_next;
    result      <= result_next;
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    pos_next         = pos;
    idx_next         = idx;
    rem_next         = rem;
    new_id_next      = new_id;
    carry_id_next    = carry_id;
    carry_delta_next = carry_delta;
    first_next       = first;
    result_next      = result;
    req.ready        = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = idx;
    mem_wdata        = mem_rdata;
    mem_raddr        = '0;
    alu_a            = rd_delta;
    alu_b            = TIME_WIDTH'(1);
    res.valid        = 1'b0;
    res.data         = result;

    unique case (state)
      S_IDLE: begin
        req.ready   = 1'b1;
        result_next = '{out_valid: 1'b0, out_id: '0, status: ST_DONE};
        if (req.valid) begin
          unique case (req.opcode)
            OP_ENQ: begin
              if (count == CW'(DEPTH)) begin
                result_next.status = ST_FULL;
                state_next         = S_RESP;
              end else begin
                rem_next    = delay_sat;
                pos_next    = '0;
                new_id_next = req.msg_id;
                state_next  = (count == '0) ? S_INS : S_WALK;
              end
            end
            OP_DEQ: begin
              if (count == '0) begin
                result_next.status = ST_NONE;
                state_next         = S_RESP;
              end else begin
                state_next = S_DEQ;
              end
            end
            OP_TICK: begin
              state_next = (count == '0) ? S_RESP : S_TICK;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      S_WALK: begin
        alu_a     = rem;
        alu_b     = rd_delta;
        mem_raddr = pos + AW'(1);
        if (!alu_lt) begin
          rem_next = alu_diff;
          pos_next = pos + AW'(1);
          if (CW'(pos) + CW'(1) == count) begin
            state_next = S_INS;
          end
        end else begin
          carry_id_next    = rd_id;
          carry_delta_next = rd_delta;
          state_next       = S_FIX;
        end
      end

      S_FIX: begin
        alu_a            = carry_delta;
        alu_b            = rem;
        carry_delta_next = alu_diff;
        state_next       = S_INS;
      end

      S_INS: begin
        mem_we     = 1'b1;
        mem_waddr  = pos;
        mem_wdata  = {new_id, rem};
        idx_next   = pos + AW'(1);
        first_next = 1'b1;
        if (CW'(pos) == count) begin
          count_next = count + CW'(1);
          state_next = S_RESP;
        end else begin
          state_next = S_RIPPLE;
        end
      end

      S_RIPPLE: begin
        mem_we     = 1'b1;
        mem_waddr  = idx;
        mem_wdata  = first ? {carry_id, carry_delta} : mem_rdata;
        mem_raddr  = idx;
        first_next = 1'b0;
        idx_next   = idx + AW'(1);
        if (CW'(idx) == count) begin
          count_next = count + CW'(1);
          state_next = S_RESP;
        end
      end

      S_DEQ: begin
        mem_raddr = AW'(1);
        idx_next  = '0;
        if (!alu_lt) begin
          result_next.status = ST_NONE;
          state_next         = S_RESP;
        end else begin
          result_next.out_valid = 1'b1;
          result_next.out_id    = rd_id;
          if (count == CW'(1)) begin
            count_next = count - CW'(1);
            state_next = S_RESP;
          end else begin
            state_next = S_DSHIFT;
          end
        end
      end

      S_DSHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        mem_raddr = idx + AW'(2);
        idx_next  = idx + AW'(1);
        if (CW'(idx) + CW'(2) == count) begin
          count_next = count - CW'(1);
          state_next = S_RESP;
        end
      end

      S_TICK: begin
        if (!alu_lt) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {rd_id, alu_diff};
        end
        state_next = S_RESP;
      end

      S_RESP: begin
        res.valid = 1'b1;
        if (res_taken) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/delta_timeout_queue_unit.sv]
// Channel  Role    Payload                      Transfer
// req      sink    opcode, msg_id, delay        valid & ready
// rsp      source  out_valid, out_id, status    valid & ready
//
// After a request's transfer, ready stays low until the sequencer is idle again; the
// walk and the shift of the slot memory take one entry per cycle through its single
// read and write port.
// A tick on a nonempty queue passes the tick state on its way to the response state;
// a full or empty rejection, an empty-queue tick and the unused opcode go to it directly.
// Reset clears the entry count and the sequencer; slot contents are not cleared.
// A result waits in the output register while the next request is accepted.
`default_nettype none

module delta_timeout_queue_unit #(
  parameter int DEPTH      = dtq_pkg::DEPTH_DEF,
  parameter int TIME_WIDTH = dtq_pkg::TIME_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  dtq_req_if.sink  req,
  dtq_rsp_if.source rsp
);
  import dtq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = ID_W + TIME_WIDTH;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [EW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [EW-1:0]         mem_rdata;
  logic [TIME_WIDTH-1:0] alu_a;
  logic [TIME_WIDTH-1:0] alu_b;
  logic [TIME_WIDTH-1:0] alu_diff;
  logic                  alu_lt;
  result_msg_t           res;
  logic                  res_taken;
  logic                  obuf_valid;
  result_t               obuf;

  dtq_seq #(
    .DEPTH      (DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_diff  (alu_diff),
    .alu_lt    (alu_lt),
    .res       (res),
    .res_taken (res_taken)
  );

  dtq_alu #(
    .WIDTH (TIME_WIDTH)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .lt   (alu_lt)
  );

  dtq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_taken = !obuf_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else if (res.valid && res_taken) begin
      obuf_valid <= 1'b1;
    end else if (rsp.ready) begin
      obuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_taken) begin
      obuf <= res.data;
    end
  end

  assign rsp.valid     = obuf_valid;
  assign rsp.out_valid = obuf.out_valid;
  assign rsp.out_id    = obuf.out_id;
  assign rsp.status    = obuf.status;

endmodule

`default_nettype wire

[rtl/dtq_checker.sv]
`default_nettype none
`include "delta_timeout_queue_unit_defines.svh"

module dtq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       rsp_out_valid,
  input logic [dtq_pkg::ID_W-1:0]   rsp_out_id,
  input logic [dtq_pkg::ST_W-1:0]   rsp_status
);
  import dtq_pkg::*;

  // A dequeued id always comes with a done status.
  `DTQ_ASSERT(a_id_done, clk, rst, !(rsp_valid && rsp_out_valid) || rsp_status == ST_DONE, "dequeued id without done status")

  // Without a dequeued id the id field reads zero.
  `DTQ_ASSERT(a_id_zero, clk, rst, !(rsp_valid && !rsp_out_valid) || rsp_out_id == '0, "id field not zero")

  // An accepted request drops ready, so no two requests transfer back to back.
  `DTQ_ASSERT_NEXT(a_busy, clk, rst, req_valid && req_ready, !req_ready, "ready right after a transfer")

  // A stalled result holds its payload.
  `DTQ_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_id) && $stable(rsp_status), "stalled result changed")

endmodule

bind delta_timeout_queue_unit dtq_checker u_dtq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_out_valid (rsp.out_valid),
  .rsp_out_id    (rsp.out_id),
  .rsp_status    (rsp.status)
);

`default_nettype wire
